// ===== rtl/mfb_pkg.sv =====
// Shared definitions for the 1bpp framebuffer line/rectangle draw unit:
// command and register codes, coordinate widths, store request/status structs.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package mfb_pkg;

	localparam int PHYS_WIDTH_DEF  = 128;
	localparam int PHYS_HEIGHT_DEF = 64;
	localparam int PIX_PER_BYTE    = 8;
	localparam logic [7:0] MASK_MSB = 8'h80;

	// Drawing coordinates: 11-bit inputs plus a rectangle extent, sums up to 2046
	localparam int CW  = 13;
	// Bresenham deltas and error term
	localparam int EW  = 16;
	// Rotated physical coordinates, signed, covers sizes up to 1024
	localparam int PCW = 12;

	typedef enum logic [1:0] {
		FUNC_LINE = 2'd0,
		FUNC_RECT = 2'd1,
		FUNC_FILL = 2'd2,
		FUNC_READ = 2'd3
	} func_t;

	localparam logic [1:0] CFG_ROTATION = 2'd0;
	localparam logic [1:0] CFG_LWIDTH   = 2'd1;
	localparam logic [1:0] CFG_LHEIGHT  = 2'd2;

	localparam logic [1:0] ROT_CW  = 2'd1;
	localparam logic [1:0] ROT_CCW = 2'd2;

	typedef struct packed {
		logic pix_valid;
		logic rd_valid;
		logic black;
	} fb_req_t;

	typedef struct packed {
		logic idle;
		logic pix_ready;
		logic rd_done;
	} fb_status_t;

	function automatic int idx_w(input int n);
		return (n > 1) ? $clog2(n) : 1;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/mfb_fb_store.sv =====
// Framebuffer store: byte memory, clearing pass after reset, pixel
// read-modify-write and byte reads. Depends on mfb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mfb_fb_store #(
	parameter int PHYS_WIDTH  = mfb_pkg::PHYS_WIDTH_DEF,
	parameter int PHYS_HEIGHT = mfb_pkg::PHYS_HEIGHT_DEF,
	localparam int BPR   = (PHYS_WIDTH + mfb_pkg::PIX_PER_BYTE - 1) / mfb_pkg::PIX_PER_BYTE,
	localparam int DEPTH = BPR * PHYS_HEIGHT,
	localparam int AW    = mfb_pkg::idx_w(DEPTH),
	localparam int PXW   = mfb_pkg::idx_w(PHYS_WIDTH),
	localparam int PYW   = mfb_pkg::idx_w(PHYS_HEIGHT)
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire mfb_pkg::fb_req_t   req,
	input  wire logic [PXW-1:0]     px,
	input  wire logic [PYW-1:0]     py,
	input  wire logic [AW-1:0]      rd_addr,
	output mfb_pkg::fb_status_t     status,
	output logic [7:0]              rd_data
);
	import mfb_pkg::*;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_CALC,
		ST_WRITE,
		ST_RDATA
	} st_t;

	st_t            state_q;
	logic [AW-1:0]  clr_cnt_q;
	logic [PXW-1:0] px_q;
	logic [PYW-1:0] py_q;
	logic           black_q;
	logic [AW-1:0]  addr_q;
	logic [7:0]     mask_q;

	logic [7:0]     mem [DEPTH];
	logic [7:0]     rdata_q;

	logic [31:0]    calc_addr;
	logic [AW-1:0]  raddr;
	logic           we;
	logic [AW-1:0]  waddr;
	logic [7:0]     wdata;
	logic           take_pix;

	assign calc_addr = 32'(py_q) * 32'(BPR) + (32'(px_q) >> 3);
	assign raddr     = (state_q == ST_CALC) ? calc_addr[AW-1:0] : rd_addr;
	assign we        = (state_q == ST_CLEAR) || (state_q == ST_WRITE);
	assign waddr     = (state_q == ST_CLEAR) ? clr_cnt_q : addr_q;
	assign wdata     = (state_q == ST_CLEAR) ? 8'hFF :
	                   (black_q ? (rdata_q & ~mask_q) : (rdata_q | mask_q));

	assign take_pix  = req.pix_valid && ((state_q == ST_IDLE) || (state_q == ST_WRITE));

	assign status.idle      = (state_q == ST_IDLE);
	assign status.pix_ready = (state_q == ST_IDLE) || (state_q == ST_WRITE);
	assign status.rd_done   = (state_q == ST_RDATA);
	assign rd_data          = rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			clr_cnt_q <= '0;
		end else begin
			case (state_q)
				ST_CLEAR: begin
					clr_cnt_q <= clr_cnt_q + AW'(1);
					if (clr_cnt_q == AW'(DEPTH - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE, ST_WRITE: begin
					if (take_pix) begin
						state_q <= ST_CALC;
					end else if (req.rd_valid && state_q == ST_IDLE) begin
						state_q <= ST_RDATA;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_CALC: begin
					state_q <= ST_WRITE;
				end
				ST_RDATA: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Payload registers: latch the pixel, then its byte address and mask
	always_ff @(posedge clk) begin
		if (take_pix) begin
			px_q    <= px;
			py_q    <= py;
			black_q <= req.black;
		end
		if (state_q == ST_CALC) begin
			addr_q <= calc_addr[AW-1:0];
			mask_q <= MASK_MSB >> px_q[2:0];
		end
	end

endmodule

`default_nettype wire

// ===== rtl/mono_framebuffer_line_rect_draw_unit.sv =====
// Top level of the 1bpp framebuffer draw unit: configuration registers,
// command sequencer with a shared Bresenham/scan stepper and pixel mapper.
// Depends on mfb_pkg and mfb_fb_store.
//
// Usage:
//   Input channel (in_valid/in_ready) takes one command word: a line, a
//   rectangle outline (four lines), a filled rectangle or a byte read.
//   Output channel (out_valid/out_ready) returns exactly one word per command:
//   the byte read for a read command, zero for a drawing command.
//   Configuration (cfg_we/cfg_index/cfg_data) sets rotation and logical clip
//   size; write it only while no command is in flight.
// Timing:
//   One command at a time; in_ready is low until its result is loaded into the
//   output register. The stepper visits one pixel position per cycle until a
//   pixel survives clipping, then waits until the store has read that pixel's
//   byte and begins writing it back. A line also passes through setup, segment
//   end and result load; an outline through an edge load, setup and segment
//   end per side; a fill also steps over each row end. A read waits for the
//   store's byte; an empty rectangle or a read past the store end skips to load.
// Reset:
//   The store is swept to white, one byte per cycle, BPR*PHYS_HEIGHT bytes
//   (1024 at the default size); in_ready stays low until the sweep is done.
// Stall:
//   A result waiting on out_ready does not block the next command from being
//   accepted; that command's result waits until the output register frees.
`timescale 1ns / 1ps
`default_nettype none

module mono_framebuffer_line_rect_draw_unit #(
	parameter int PHYS_WIDTH  = mfb_pkg::PHYS_WIDTH_DEF,
	parameter int PHYS_HEIGHT = mfb_pkg::PHYS_HEIGHT_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	// command channel
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [1:0]         func,
	input  wire logic signed [10:0] start_x,
	input  wire logic signed [10:0] start_y,
	input  wire logic signed [10:0] end_x_or_width,
	input  wire logic signed [10:0] end_y_or_height,
	input  wire logic               black,
	input  wire logic [9:0]         read_address,
	// result channel
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic [7:0]              read_data,
	// configuration write port
	input  wire logic               cfg_we,
	input  wire logic [1:0]         cfg_index,
	input  wire logic [7:0]         cfg_data
);
	import mfb_pkg::*;

	localparam int BPR   = (PHYS_WIDTH + PIX_PER_BYTE - 1) / PIX_PER_BYTE;
	localparam int DEPTH = BPR * PHYS_HEIGHT;
	localparam int AW    = idx_w(DEPTH);
	localparam int PXW   = idx_w(PHYS_WIDTH);
	localparam int PYW   = idx_w(PHYS_HEIGHT);

	typedef enum logic [3:0] {
		S_IDLE,
		S_EDGE,
		S_SETUP,
		S_LINE,
		S_FILL,
		S_WAIT,
		S_SEGEND,
		S_READ,
		S_RWAIT,
		S_DONE
	} state_t;

	// configuration
	logic [1:0] rot_q;
	logic [7:0] lwidth_q;
	logic [7:0] lheight_q;

	// sequencer
	state_t               state_q;
	func_t                func_q;
	logic                 black_q;
	logic [1:0]           edge_q;
	logic                 last_q;
	logic signed [CW-1:0] cx_q, cy_q;     // current position
	logic signed [CW-1:0] ex_q, ey_q;     // line end
	logic signed [CW-1:0] rx_q, ry_q;     // rectangle corner / fill column start
	logic signed [CW-1:0] rx2_q, ry2_q;   // far corner / fill column and row limit
	logic signed [EW-1:0] dx_q, dy_q, err_q;
	logic                 sx_neg_q, sy_neg_q;
	logic [AW-1:0]        raddr_q;
	logic [7:0]           result_q;
	logic                 out_valid_q;
	logic [7:0]           read_data_q;

	fb_req_t    fb_req;
	fb_status_t fb_st;
	logic [7:0] fb_rd_data;

	//------------------------------------------------------------------
	// Configuration registers
	//------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rot_q     <= 2'd0;
			lwidth_q  <= 8'd128;
			lheight_q <= 8'd64;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_ROTATION: rot_q     <= cfg_data[1:0];
				CFG_LWIDTH:   lwidth_q  <= cfg_data;
				CFG_LHEIGHT:  lheight_q <= cfg_data;
				default: ;
			endcase
		end
	end

	//------------------------------------------------------------------
	// Command decode at acceptance
	//------------------------------------------------------------------
	logic                 accept;
	logic signed [CW-1:0] in_x, in_y, in_a, in_b;
	logic signed [CW-1:0] lw_s, lh_s;
	logic signed [CW-1:0] x_end, y_end;
	logic                 rect_ok;
	logic                 addr_ok;

	assign in_ready = (state_q == S_IDLE) && fb_st.idle;
	assign accept   = in_valid && in_ready;

	assign in_x    = CW'(start_x);
	assign in_y    = CW'(start_y);
	assign in_a    = CW'(end_x_or_width);
	assign in_b    = CW'(end_y_or_height);
	assign lw_s    = $signed({{(CW-8){1'b0}}, lwidth_q});
	assign lh_s    = $signed({{(CW-8){1'b0}}, lheight_q});
	assign x_end   = in_x + in_a;
	assign y_end   = in_y + in_b;
	assign rect_ok = (in_a > 0) && (in_b > 0);
	assign addr_ok = 32'(read_address) < 32'(DEPTH);

	//------------------------------------------------------------------
	// Pixel mapper: logical clip, rotate, physical clip
	//------------------------------------------------------------------
	logic                  in_log;
	logic [7:0]            x8, y8;
	logic signed [PCW-1:0] x_p, y_p, rpx, rpy;
	logic                  pix_ok;

	assign in_log = !cx_q[CW-1] && !cy_q[CW-1] && (cx_q < lw_s) && (cy_q < lh_s);
	assign x8     = cx_q[7:0];
	assign y8     = cy_q[7:0];
	assign x_p    = $signed({{(PCW-8){1'b0}}, x8});
	assign y_p    = $signed({{(PCW-8){1'b0}}, y8});

	always_comb begin
		case (rot_q)
			ROT_CW: begin
				rpx = PCW'(PHYS_WIDTH - 1) - y_p;
				rpy = x_p;
			end
			ROT_CCW: begin
				rpx = y_p;
				rpy = PCW'(PHYS_HEIGHT - 1) - x_p;
			end
			default: begin
				rpx = x_p;
				rpy = y_p;
			end
		endcase
	end

	assign pix_ok = in_log && !rpx[PCW-1] && !rpy[PCW-1] &&
	                (rpx < PCW'(PHYS_WIDTH)) && (rpy < PCW'(PHYS_HEIGHT));

	//------------------------------------------------------------------
	// Stepper arithmetic
	//------------------------------------------------------------------
	logic signed [EW-1:0] ddx, ddy, adx, ady, e2, err_n;
	logic                 step_x, step_y, line_done;
	logic signed [CW-1:0] cx_step, cy_step;
	logic                 fill_row_end, fill_end, fill_pix;
	logic                 pix_hold;

	assign ddx = EW'(ex_q) - EW'(cx_q);
	assign ddy = EW'(ey_q) - EW'(cy_q);
	assign adx = ddx[EW-1] ? -ddx : ddx;
	assign ady = ddy[EW-1] ? -ddy : ddy;

	assign e2      = err_q <<< 1;
	assign step_x  = e2 >= dy_q;
	assign step_y  = e2 <= dx_q;
	assign err_n   = err_q + (step_x ? dy_q : EW'(0)) + (step_y ? dx_q : EW'(0));
	assign cx_step = sx_neg_q ? cx_q - CW'(1) : cx_q + CW'(1);
	assign cy_step = sy_neg_q ? cy_q - CW'(1) : cy_q + CW'(1);
	assign line_done = (cx_q == ex_q) && (cy_q == ey_q);

	assign fill_end     = cy_q >= ry2_q;
	assign fill_row_end = cx_q >= rx2_q;
	assign fill_pix     = !fill_end && !fill_row_end;

	// hold the stepper while the store cannot take a surviving pixel
	assign pix_hold = pix_ok && !fb_st.pix_ready;

	always_comb begin
		fb_req.pix_valid = pix_ok && fb_st.pix_ready &&
		                   ((state_q == S_LINE) || ((state_q == S_FILL) && fill_pix));
		fb_req.rd_valid  = (state_q == S_READ) && fb_st.idle;
		fb_req.black     = black_q;
	end

	//------------------------------------------------------------------
	// Sequencer
	//------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			// drop the word once taken, unless a new one is loaded below
			if (out_valid_q && out_ready && state_q != S_DONE) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						func_q   <= func_t'(func);
						black_q  <= black;
						result_q <= 8'd0;
						case (func_t'(func))
							FUNC_LINE: begin
								cx_q    <= in_x;
								cy_q    <= in_y;
								ex_q    <= in_a;
								ey_q    <= in_b;
								state_q <= S_SETUP;
							end
							FUNC_RECT: begin
								rx_q    <= in_x;
								ry_q    <= in_y;
								rx2_q   <= x_end - CW'(1);
								ry2_q   <= y_end - CW'(1);
								edge_q  <= 2'd0;
								state_q <= rect_ok ? S_EDGE : S_DONE;
							end
							FUNC_FILL: begin
								rx_q    <= in_x[CW-1] ? CW'(0) : in_x;
								cx_q    <= in_x[CW-1] ? CW'(0) : in_x;
								cy_q    <= in_y[CW-1] ? CW'(0) : in_y;
								rx2_q   <= (x_end < lw_s) ? x_end : lw_s;
								ry2_q   <= (y_end < lh_s) ? y_end : lh_s;
								state_q <= rect_ok ? S_FILL : S_DONE;
							end
							default: begin
								raddr_q <= AW'(read_address);
								state_q <= addr_ok ? S_READ : S_DONE;
							end
						endcase
					end
				end
				S_EDGE: begin
					// top, bottom, left, right sides of the outline
					case (edge_q)
						2'd0: begin
							cx_q <= rx_q;  cy_q <= ry_q;  ex_q <= rx2_q; ey_q <= ry_q;
						end
						2'd1: begin
							cx_q <= rx_q;  cy_q <= ry2_q; ex_q <= rx2_q; ey_q <= ry2_q;
						end
						2'd2: begin
							cx_q <= rx_q;  cy_q <= ry_q;  ex_q <= rx_q;  ey_q <= ry2_q;
						end
						default: begin
							cx_q <= rx2_q; cy_q <= ry_q;  ex_q <= rx2_q; ey_q <= ry2_q;
						end
					endcase
					state_q <= S_SETUP;
				end
				S_SETUP: begin
					dx_q     <= adx;
					dy_q     <= -ady;
					err_q    <= adx - ady;
					sx_neg_q <= !(cx_q < ex_q);
					sy_neg_q <= !(cy_q < ey_q);
					state_q  <= S_LINE;
				end
				S_LINE: begin
					if (!pix_hold) begin
						if (!line_done) begin
							err_q <= err_n;
							if (step_x) begin
								cx_q <= cx_step;
							end
							if (step_y) begin
								cy_q <= cy_step;
							end
						end
						if (pix_ok) begin
							last_q  <= line_done;
							state_q <= S_WAIT;
						end else if (line_done) begin
							state_q <= S_SEGEND;
						end
					end
				end
				S_FILL: begin
					if (fill_end) begin
						state_q <= S_DONE;
					end else if (fill_row_end) begin
						cx_q <= rx_q;
						cy_q <= cy_q + CW'(1);
					end else if (!pix_hold) begin
						cx_q <= cx_q + CW'(1);
						if (pix_ok) begin
							last_q  <= 1'b0;
							state_q <= S_WAIT;
						end
					end
				end
				S_WAIT: begin
					if (fb_st.pix_ready) begin
						if (last_q) begin
							state_q <= S_SEGEND;
						end else if (func_q == FUNC_FILL) begin
							state_q <= S_FILL;
						end else begin
							state_q <= S_LINE;
						end
					end
				end
				S_SEGEND: begin
					if (func_q == FUNC_RECT && edge_q != 2'd3) begin
						edge_q  <= edge_q + 2'd1;
						state_q <= S_EDGE;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_READ: begin
					if (fb_st.idle) begin
						state_q <= S_RWAIT;
					end
				end
				S_RWAIT: begin
					if (fb_st.rd_done) begin
						result_q <= fb_rd_data;
						state_q  <= S_DONE;
					end
				end
				S_DONE: begin
					// load the result once the output register is free
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						read_data_q <= result_q;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign read_data = read_data_q;

	//------------------------------------------------------------------
	// Framebuffer store
	//------------------------------------------------------------------
	mfb_fb_store #(
		.PHYS_WIDTH  (PHYS_WIDTH),
		.PHYS_HEIGHT (PHYS_HEIGHT)
	) u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (fb_req),
		.px      (rpx[PXW-1:0]),
		.py      (rpy[PYW-1:0]),
		.rd_addr (raddr_q),
		.status  (fb_st),
		.rd_data (fb_rd_data)
	);

endmodule

`default_nettype wire

// ===== dv/testbench.sv =====
// Self-checking bench for mono_framebuffer_line_rect_draw_unit: directed and random draw/read
// commands with random idling on both channels, results checked against an in-bench framebuffer.
// Depends on mfb_pkg and the draw unit RTL.
`timescale 1ns / 1ps

module testbench;
	import mfb_pkg::*;

	localparam int PW = PHYS_WIDTH_DEF;
	localparam int PH = PHYS_HEIGHT_DEF;
	localparam int BPR = (PW + PIX_PER_BYTE - 1) / PIX_PER_BYTE;
	localparam int STORE_BYTES = BPR * PH;
	localparam int NUM_DIRECTED = 25;
	localparam int NUM_SETTINGS = 9;
	localparam int WORDS_PER_SETTING = 120;

	// One directed command; want is used only when known is set, otherwise the
	// framebuffer model supplies the expected word.
	typedef struct packed {
		func_t op;
		int sx;
		int sy;
		int ex;
		int ey;
		bit blk;
		int addr;
		bit known;
		logic [7:0] want;
	} cmd_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [1:0] func = FUNC_LINE;
	logic signed [10:0] start_x = '0;
	logic signed [10:0] start_y = '0;
	logic signed [10:0] end_x_or_width = '0;
	logic signed [10:0] end_y_or_height = '0;
	logic black = 1'b0;
	logic [9:0] read_address = '0;
	logic out_valid;
	logic out_ready = 1'b1;
	logic [7:0] read_data;
	logic cfg_we = 1'b0;
	logic [1:0] cfg_index = CFG_ROTATION;
	logic [7:0] cfg_data = '0;

	// Framebuffer model and its copy of the configuration registers
	logic [7:0] pixel_bytes [STORE_BYTES];
	logic [1:0] rot_mode = 2'd0;
	int lw = 128;
	int lh = 64;

	logic [7:0] expected_bytes [$];
	logic [7:0] want_byte;
	int px_visits, row_visits;
	int cmds_sent = 0, reads_sent = 0, words_checked = 0, mismatches = 0, settings_used = 1;
	int tx_calm = 0, rx_calm = 0, rx_hold = 0;
	int cycle_count = 0;
	// Grows with every accepted command by a generous multiple of its cost
	int cycle_budget = 4 * STORE_BYTES + 4000;

	// Register settings walked by the random part; the first one is the reset state
	int setting_rot [NUM_SETTINGS] = '{0, 1, 2, 3, 0, 1, 0, 2, 0};
	int setting_lw [NUM_SETTINGS] = '{128, 64, 128, 100, 0, 128, 1, 64, 128};
	int setting_lh [NUM_SETTINGS] = '{64, 128, 128, 50, 0, 128, 1, 128, 64};

	// Directed commands, run at the reset configuration (no rotation, 128 x 64)
	cmd_row_t directed_rows [NUM_DIRECTED] = '{
		// fresh store reads white at both ends
		'{FUNC_READ, 0, 0, 0, 0, 1'b0, 0, 1'b1, 8'hFF},
		'{FUNC_READ, 0, 0, 0, 0, 1'b0, 1023, 1'b1, 8'hFF},
		// single-pixel lines in opposite corners
		'{FUNC_LINE, 0, 0, 0, 0, 1'b1, 0, 1'b1, 8'h00},
		'{FUNC_READ, 0, 0, 0, 0, 1'b0, 0, 1'b1, 8'h7F},
		'{FUNC_LINE, 127, 63, 127, 63, 1'b1, 0, 1'b1, 8'h00},
		'{FUNC_READ, 0, 0, 0, 0, 1'b0, 1023, 1'b1, 8'hFE},
		// one full byte blacked by a fill
		'{FUNC_FILL, 8, 1, 8, 1, 1'b1, 0, 1'b1, 8'h00},
		'{FUNC_READ, 0, 0, 0, 0, 1'b0, 17, 1'b1, 8'h00},
		// empty rectangle: zero width leaves the byte alone
		'{FUNC_RECT, 8, 1, 0, 5, 1'b0, 0, 1'b1, 8'h00},
		'{FUNC_READ, 0, 0, 0, 0, 1'b0, 17, 1'b1, 8'h00},
		// extremes: negative height, everything off canvas, corner-to-corner diagonals, canvas outline, oversized fill
		'{FUNC_FILL, -1024, -1024, 1023, -1024, 1'b1, 0, 1'b1, 8'h00},
		'{FUNC_RECT, 1023, 1023, 1023, 1023, 1'b0, 0, 1'b1, 8'h00},
		'{FUNC_LINE, -1024, -1024, 1023, 1023, 1'b0, 0, 1'b1, 8'h00},
		'{FUNC_READ, 0, 0, 0, 0, 1'b0, 0, 1'b0, 8'h00},
		'{FUNC_LINE, 1023, -1024, -1024, 1023, 1'b1, 0, 1'b0, 8'h00},
		'{FUNC_RECT, 0, 0, 128, 64, 1'b1, 0, 1'b0, 8'h00},
		'{FUNC_READ, 0, 0, 0, 0, 1'b0, 16, 1'b0, 8'h00},
		'{FUNC_FILL, 60, 20, 1023, 1023, 1'b1, 0, 1'b0, 8'h00},
		'{FUNC_READ, 0, 0, 0, 0, 1'b0, 1023, 1'b0, 8'h00},
		// whole canvas back to white
		'{FUNC_FILL, 0, 0, 128, 64, 1'b0, 0, 1'b1, 8'h00},
		'{FUNC_READ, 0, 0, 0, 0, 1'b0, 500, 1'b1, 8'hFF},
		'{FUNC_READ, -1, -1, -1, -1, 1'b1, 1023, 1'b1, 8'hFF},
		// shallow and steep lines
		'{FUNC_LINE, 5, 3, 40, 17, 1'b1, 0, 1'b0, 8'h00},
		'{FUNC_LINE, 40, 60, 35, 2, 1'b1, 0, 1'b0, 8'h00},
		'{FUNC_READ, 0, 0, 0, 0, 1'b0, 48, 1'b0, 8'h00}
	};

	mono_framebuffer_line_rect_draw_unit #(
		.PHYS_WIDTH(PW),
		.PHYS_HEIGHT(PH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.func(func),
		.start_x(start_x),
		.start_y(start_y),
		.end_x_or_width(end_x_or_width),
		.end_y_or_height(end_y_or_height),
		.black(black),
		.read_address(read_address),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.read_data(read_data),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Write one pixel: clip to the logical canvas, rotate, clip to the panel.
	function automatic void paint_pixel(int x, int y, bit blk);
		int px = x;
		int py = y;
		int idx;
		logic [7:0] mask;
		px_visits++;
		if (x < 0 || y < 0 || x >= lw || y >= lh)
			return;
		if (rot_mode == ROT_CW) begin
			px = PW - 1 - y;
			py = x;
		end else if (rot_mode == ROT_CCW) begin
			px = y;
			py = PH - 1 - x;
		end
		if (px < 0 || py < 0 || px >= PW || py >= PH)
			return;
		idx = py * BPR + px / PIX_PER_BYTE;
		if (idx >= STORE_BYTES)
			return;
		mask = MASK_MSB >> (px % PIX_PER_BYTE);
		if (blk)
			pixel_bytes[idx] = pixel_bytes[idx] & ~mask;
		else
			pixel_bytes[idx] = pixel_bytes[idx] | mask;
	endfunction

	// Bresenham walk from (x0, y0) to (x1, y1), both ends included
	function automatic void trace_line(int x0, int y0, int x1, int y1, bit blk);
		int dx = (x1 > x0) ? x1 - x0 : x0 - x1;
		int dy = -((y1 > y0) ? y1 - y0 : y0 - y1);
		int sx = (x0 < x1) ? 1 : -1;
		int sy = (y0 < y1) ? 1 : -1;
		int err = dx + dy;
		int e2;
		while (1'b1) begin
			paint_pixel(x0, y0, blk);
			if (x0 == x1 && y0 == y1)
				break;
			e2 = 2 * err;
			if (e2 >= dy) begin
				err += dy;
				x0 += sx;
			end
			if (e2 <= dx) begin
				err += dx;
				y0 += sy;
			end
		end
	endfunction

	// Filled rectangle, scanned only over its part inside the logical canvas
	function automatic void fill_box(int x, int y, int w, int h, bit blk);
		int xa = (x < 0) ? 0 : x;
		int ya = (y < 0) ? 0 : y;
		int xb = (x + w < lw) ? x + w : lw;
		int yb = (y + h < lh) ? y + h : lh;
		for (int yy = ya; yy < yb; yy++) begin
			row_visits++;
			for (int xx = xa; xx < xb; xx++)
				paint_pixel(xx, yy, blk);
		end
	endfunction

	// Apply one command to the framebuffer model and return the word it produces
	function automatic logic [7:0] predict_command(func_t op, int x, int y, int a, int b,
			bit blk, int addr);
		logic [7:0] word = 8'h00;
		case (op)
			FUNC_LINE: begin
				trace_line(x, y, a, b, blk);
			end
			FUNC_RECT: begin
				if (a > 0 && b > 0) begin
					trace_line(x, y, x + a - 1, y, blk);
					trace_line(x, y + b - 1, x + a - 1, y + b - 1, blk);
					trace_line(x, y, x, y + b - 1, blk);
					trace_line(x + a - 1, y, x + a - 1, y + b - 1, blk);
				end
			end
			FUNC_FILL: begin
				if (a > 0 && b > 0)
					fill_box(x, y, a, b, blk);
			end
			default: begin
				// reads past the end of the store return zero
				if (addr < STORE_BYTES)
					word = pixel_bytes[addr];
			end
		endcase
		return word;
	endfunction

	// Idle length for one word: mostly a random gap, with calm stretches of none
	task automatic pick_gap(inout int calm, output int gap);
		if (calm > 0) begin
			calm--;
			gap = 0;
		end else if ($urandom_range(0, 15) == 0) begin
			calm = int'($urandom_range(10, 40));
			gap = 0;
		end else begin
			gap = int'($urandom_range(0, 13));
		end
	endtask

	// Mostly near the canvas, sometimes anywhere in the 11-bit range
	function automatic int pick_coord();
		if ($urandom_range(0, 9) == 0)
			return int'($urandom_range(0, 2047)) - 1024;
		return int'($urandom_range(0, 150)) - 10;
	endfunction

	// Rectangle extent, a few of them not positive; huge fills stay rare
	function automatic int pick_extent(func_t op);
		if ($urandom_range(0, (op == FUNC_FILL) ? 49 : 9) == 0)
			return int'($urandom_range(0, 2047)) - 1024;
		if (op == FUNC_FILL)
			return int'($urandom_range(0, 26)) - 2;
		return int'($urandom_range(0, 42)) - 2;
	endfunction

	// Present one command word, hold it until accepted, then record its result
	task automatic send_cmd(func_t op, int sx, int sy, int ex, int ey, bit blk, int addr,
			bit known, logic [7:0] want);
		int gap;
		logic [7:0] predicted;
		pick_gap(tx_calm, gap);
		// drop valid only when an idle gap follows; a back-to-back word keeps it high
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		func <= op;
		start_x <= sx[10:0];
		start_y <= sy[10:0];
		end_x_or_width <= ex[10:0];
		end_y_or_height <= ey[10:0];
		black <= blk;
		read_address <= addr[9:0];
		in_valid <= 1'b1;
		do
			@(posedge clk);
		while (!in_ready);
		px_visits = 0;
		row_visits = 0;
		predicted = predict_command(op, sx, sy, ex, ey, blk, addr);
		expected_bytes.push_back(known ? want : predicted);
		// budget grows with the pixels and rows visited, plus setup and both idle gaps
		cycle_budget += 4 * (3 * px_visits + row_visits + 60);
		cmds_sent++;
		if (op == FUNC_READ)
			reads_sent++;
	endtask

	// Drop valid, wait for every outstanding result, then let the unit settle
	task automatic drain();
		in_valid <= 1'b0;
		while (expected_bytes.size() != 0)
			@(posedge clk);
		cycle_budget += 40;
		repeat (8) @(posedge clk);
	endtask

	// Result side: check each word against the oldest expectation, then stall a while
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (expected_bytes.size() == 0) begin
					$error("read_data: unexpected word %02h with nothing outstanding", read_data);
					mismatches++;
				end else begin
					want_byte = expected_bytes.pop_front();
					words_checked++;
					if (read_data !== want_byte) begin
						$error("read_data mismatch: expected %02h, got %02h", want_byte,
							read_data);
						mismatches++;
					end
				end
				pick_gap(rx_calm, rx_hold);
				out_ready <= (rx_hold == 0);
			end else if (!out_ready) begin
				if (rx_hold > 0)
					rx_hold--;
				if (rx_hold == 0)
					out_ready <= 1'b1;
			end
		end
	end

	// Watchdog: the budget tracks what the accepted commands may cost
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > cycle_budget) begin
			$display("tb: failure");
			$finish;
		end
	end

	initial begin
		cmd_row_t row;
		func_t op;
		int pick, sx, sy, ex, ey;
		bit blk;
		for (int i = 0; i < STORE_BYTES; i++)
			pixel_bytes[i] = 8'hFF;

		// hold reset, then release; the store sweep keeps in_ready low for a while
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		for (int i = 0; i < NUM_DIRECTED; i++) begin
			row = directed_rows[i];
			send_cmd(row.op, row.sx, row.sy, row.ex, row.ey, row.blk, row.addr, row.known,
				row.want);
		end

		for (int s = 0; s < NUM_SETTINGS; s++) begin
			if (s > 0) begin
				// reprogram only with nothing in flight
				drain();
				cfg_we <= 1'b1;
				cfg_index <= CFG_ROTATION;
				cfg_data <= 8'(setting_rot[s]);
				@(posedge clk);
				cfg_index <= CFG_LWIDTH;
				cfg_data <= 8'(setting_lw[s]);
				@(posedge clk);
				cfg_index <= CFG_LHEIGHT;
				cfg_data <= 8'(setting_lh[s]);
				@(posedge clk);
				cfg_we <= 1'b0;
				rot_mode = 2'(setting_rot[s]);
				lw = setting_lw[s];
				lh = setting_lh[s];
				settings_used++;
			end
			for (int n = 0; n < WORDS_PER_SETTING; n++) begin
				pick = int'($urandom_range(0, 99));
				op = (pick < 30) ? FUNC_LINE : (pick < 45) ? FUNC_RECT :
					(pick < 60) ? FUNC_FILL : FUNC_READ;
				sx = pick_coord();
				sy = pick_coord();
				if (op == FUNC_LINE) begin
					ex = pick_coord();
					ey = pick_coord();
				end else begin
					ex = pick_extent(op);
					ey = pick_extent(op);
				end
				blk = 1'($urandom_range(0, 1));
				send_cmd(op, sx, sy, ex, ey, blk, int'($urandom_range(0, 1023)), 1'b0, 8'h00);
			end
		end

		drain();
		$display("summary: %0d commands (%0d byte reads) across %0d register settings",
			cmds_sent, reads_sent, settings_used);
		$display("summary: %0d result words checked, %0d mismatches", words_checked,
			mismatches);
		if (mismatches == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
